// ===== design/tks_pkg.sv =====
// Shared types, constants and control bundles of the top-k score selector.
package tks_pkg;

    // Store size and field widths
    localparam int CAPACITY  = 16;
    localparam int TAG_BITS  = 16;
    localparam int SCORE_W   = 32;
    localparam int COUNT_W   = $clog2(CAPACITY + 1);
    localparam int KEEP_W    = 5;
    localparam int CMP_W     = (COUNT_W > KEEP_W) ? COUNT_W : KEEP_W;

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic [PADDR_W-1:0] ADDR_KEEP_COUNT = PADDR_W'(0);
    localparam logic [KEEP_W-1:0]  KEEP_RESET      = KEEP_W'(16);

    // Operation codes
    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic                        operation;
        logic signed [SCORE_W-1:0]   score;
        logic [TAG_BITS-1:0]         item_tag;
    } in_item_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0]   out_score;
        logic [TAG_BITS-1:0]         out_tag;
        logic                        is_empty;
        logic                        last;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_insert;
        logic drain_step;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic               item_is_drain;
        logic               count_le_one;
        logic               out_free;
        logic [COUNT_W-1:0] count;
    } status_t;

endpackage

// ===== design/tks_ctrl.sv =====
// Controller state machine of the top-k score selector.
module tks_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  tks_pkg::status_t status,
    output tks_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_INSERT = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        item_ready     = 1'b0;
        cmd.load_item  = 1'b0;
        cmd.do_insert  = 1'b0;
        cmd.drain_step = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                // The registered item decides between insertion and drain.
                if (status.item_is_drain)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.do_insert = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (status.out_free)
                begin
                    cmd.drain_step = 1'b1;
                    if (status.count_le_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/tks_datapath.sv =====
// Datapath of the top-k score selector: sorted store, item register and result register.
module tks_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tks_pkg::in_item_t              item,
    input  logic [tks_pkg::KEEP_W-1:0]     keep_count,
    input  tks_pkg::cmd_t                  cmd,
    output tks_pkg::status_t               status,
    output tks_pkg::out_item_t             result,
    output logic                           result_valid,
    input  logic                           result_ready
);

    tks_pkg::in_item_t                        item_reg;
    logic signed [tks_pkg::SCORE_W-1:0]       score_reg [tks_pkg::CAPACITY];
    logic [tks_pkg::TAG_BITS-1:0]             tag_reg   [tks_pkg::CAPACITY];
    logic [tks_pkg::COUNT_W-1:0]              count_reg;
    logic [tks_pkg::COUNT_W-1:0]              count_next;
    tks_pkg::out_item_t                       result_reg;
    logic                                     result_valid_reg;

    logic [tks_pkg::CAPACITY-1:0]             stay;
    logic [tks_pkg::CAPACITY-1:0]             new_at;
    logic                                     beats_min;
    logic                                     room;
    logic [tks_pkg::CMP_W-1:0]                limit;
    logic [tks_pkg::CMP_W-1:0]                count_ext;
    logic                                     insert_en;

    // Effective retention limit, clamped to one and to the store size
    always_comb
    begin
        priority if (keep_count == '0)
        begin
            limit = tks_pkg::CMP_W'(1);
        end
        else if (tks_pkg::CMP_W'(keep_count) > tks_pkg::CMP_W'(tks_pkg::CAPACITY))
        begin
            limit = tks_pkg::CMP_W'(tks_pkg::CAPACITY);
        end
        else
        begin
            limit = tks_pkg::CMP_W'(keep_count);
        end
    end

    assign count_ext = tks_pkg::CMP_W'(count_reg);
    assign room      = count_ext < limit;

    // Insert position: entries at or above the new score stay, the rest move down.
    // Equal scores stay ahead, so ties come out oldest first.
    always_comb
    begin
        beats_min = 1'b0;
        for (int i = 0; i < tks_pkg::CAPACITY; i++)
        begin
            stay[i] = (tks_pkg::COUNT_W'(i) < count_reg) && (score_reg[i] >= item_reg.score);
            if ((tks_pkg::COUNT_W'(i) < count_reg) && !stay[i])
            begin
                beats_min = 1'b1;
            end
        end
        for (int i = 0; i < tks_pkg::CAPACITY; i++)
        begin
            if (i == 0)
            begin
                new_at[i] = !stay[i];
            end
            else
            begin
                new_at[i] = !stay[i] && stay[i-1];
            end
        end
    end

    // A full store drops its last (newest lowest) entry when a higher score arrives.
    assign insert_en = cmd.do_insert && (room || beats_min);

    always_comb
    begin
        count_next = count_reg;
        if (insert_en && room)
        begin
            count_next = count_reg + tks_pkg::COUNT_W'(1);
        end
        else if (cmd.drain_step && (count_reg != '0))
        begin
            count_next = count_reg - tks_pkg::COUNT_W'(1);
        end
    end

    // Item register
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
    end

    // Sorted store: shift in on insertion, shift towards the head on drain
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < tks_pkg::CAPACITY; i++)
        begin
            if (insert_en)
            begin
                if (new_at[i])
                begin
                    score_reg[i] <= item_reg.score;
                    tag_reg[i]   <= item_reg.item_tag;
                end
                else if (!stay[i] && (i > 0))
                begin
                    score_reg[i] <= score_reg[(i > 0) ? i - 1 : 0];
                    tag_reg[i]   <= tag_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (cmd.drain_step && (i < tks_pkg::CAPACITY - 1))
            begin
                score_reg[i] <= score_reg[(i < tks_pkg::CAPACITY - 1) ? i + 1 : i];
                tag_reg[i]   <= tag_reg[(i < tks_pkg::CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    // Held count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Result register: head of the store, or the empty marker
    always_ff @(posedge clk)
    begin
        if (cmd.drain_step)
        begin
            if (count_reg == '0)
            begin
                result_reg.out_score <= '0;
                result_reg.out_tag   <= '0;
                result_reg.is_empty  <= 1'b1;
                result_reg.last      <= 1'b1;
            end
            else
            begin
                result_reg.out_score <= score_reg[0];
                result_reg.out_tag   <= tag_reg[0];
                result_reg.is_empty  <= 1'b0;
                result_reg.last      <= (count_reg == tks_pkg::COUNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.drain_step)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign status.item_is_drain = (item_reg.operation == tks_pkg::OP_DRAIN);
    assign status.count_le_one  = (count_reg <= tks_pkg::COUNT_W'(1));
    assign status.out_free      = !result_valid_reg || result_ready;
    assign status.count         = count_reg;

endmodule

// ===== design/top_k_score_selector_unit.sv =====
// Top level of the top-k score selector: configuration register and module wiring.
//
//  Channel   Signals                                   Direction  Content
//  item      item_valid, item_ready, item              in         offer or drain request
//  result    result_valid, result_ready, result        out        drained item, descending
//  config    psel, penable, pwrite, paddr, pwdata,     in/out     keep_count at address 0
//            prdata, pready
//
// An offer is accepted into the item register, then inserted by a compare-and-shift
// across the sorted register store.
// A drain of n held items is accepted, then decoded from the item register, then gives
// one result per cycle while the result register is free (a single empty marker when
// the store is empty), as the store shifts towards its head. A stalled result holds the
// drain; a new item is taken only once the previous offer or drain completes.
// Reset empties the store and sets keep_count to 16; held entries need no clearing.
module top_k_score_selector_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  tks_pkg::in_item_t               item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output tks_pkg::out_item_t              result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tks_pkg::PADDR_W-1:0]     paddr,
    input  logic [tks_pkg::PDATA_W-1:0]     pwdata,
    output logic [tks_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    logic [tks_pkg::KEEP_W-1:0] keep_count_reg;
    tks_pkg::cmd_t              cmd;
    tks_pkg::status_t           status;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= tks_pkg::KEEP_RESET;
        end
        else if (psel && penable && pwrite && (paddr == tks_pkg::ADDR_KEEP_COUNT))
        begin
            keep_count_reg <= pwdata[tks_pkg::KEEP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == tks_pkg::ADDR_KEEP_COUNT) ?
                    tks_pkg::PDATA_W'(keep_count_reg) : '0;

    // Controller
    tks_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath
    tks_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .keep_count   (keep_count_reg),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // The held count never exceeds the store size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.count <= tks_pkg::COUNT_W'(tks_pkg::CAPACITY))
        else $error("held count exceeds capacity");

    // A drain step only fires when the result register can take it.
    a_drain_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_step |-> status.out_free)
        else $error("drain step overwrote a pending result");

    // The final drain step leaves the store empty.
    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.drain_step && status.count_le_one) |=> (status.count == '0))
        else $error("store not empty after final drain step");

    // An empty-drain result is always the last of its drain.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_empty) |-> result.last)
        else $error("empty result without last");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the top-k score selector: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;

    // Run limits
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 440;
    localparam int PRINT_LIMIT   = 100;
    localparam logic [tks_pkg::PADDR_W-1:0] ADDR_SPARE = tks_pkg::PADDR_W'(4);

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        tks_pkg::in_item_t               it;
        bit                              typed;
        tks_pkg::out_item_t              exp;
        logic [tks_pkg::PADDR_W-1:0]     addr;
        logic [tks_pkg::PDATA_W-1:0]     data;
    } plan_row_t;

    // Clock and DUT connections
    logic                            clk;
    logic                            rst_n          = 1'b0;
    logic                            item_valid     = 1'b0;
    logic                            item_ready;
    tks_pkg::in_item_t               item           = '0;
    logic                            result_valid;
    logic                            result_ready   = 1'b0;
    tks_pkg::out_item_t              result;
    logic                            psel           = 1'b0;
    logic                            penable        = 1'b0;
    logic                            pwrite         = 1'b0;
    logic [tks_pkg::PADDR_W-1:0]     paddr          = '0;
    logic [tks_pkg::PDATA_W-1:0]     pwdata         = '0;
    logic [tks_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;

    // A typed expectation travels alongside the item it belongs to.
    logic                            item_typed     = 1'b0;
    tks_pkg::out_item_t              item_typed_exp = '0;

    // Own copy of the selector state
    logic signed [tks_pkg::SCORE_W-1:0]  kept_score [tks_pkg::CAPACITY];
    logic [tks_pkg::TAG_BITS-1:0]        kept_tag   [tks_pkg::CAPACITY];
    int unsigned                         kept_count = 0;
    logic [tks_pkg::KEEP_W-1:0]          keep_reg   = tks_pkg::KEEP_RESET;

    tks_pkg::out_item_t   drain_expect [$];
    tks_pkg::out_item_t   want;
    plan_row_t            plan [$];

    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned items_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned drains_taken  = 0;
    int unsigned reg_writes    = 0;
    int unsigned burst_left    = 0;
    bit          tx_bursty     = 1'b1;
    logic        rx_stalling   = 1'b1;
    bit          rx_on         = 1'b1;
    int unsigned rx_left       = 0;

    top_k_score_selector_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Prints one line per mismatch, up to a limit, and counts every one.
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH at cycle %0d: %s: got %h, expected %h",
                     cycle_count, what, got, exp_val);
    endtask

    // Sorted insert into the held store, which has room for one more entry.
    function automatic void insert_kept(logic signed [tks_pkg::SCORE_W-1:0] s,
                                        logic [tks_pkg::TAG_BITS-1:0] t);
        int unsigned pos;
        pos = 0;
        while (pos < kept_count && kept_score[pos] >= s)
            pos++;
        for (int unsigned i = kept_count; i > pos; i--)
        begin
            kept_score[i] = kept_score[i-1];
            kept_tag[i]   = kept_tag[i-1];
        end
        kept_score[pos] = s;
        kept_tag[pos]   = t;
        kept_count++;
    endfunction

    // Updates the held store for one item; a drain also queues its results when asked.
    function automatic void predict_selector(tks_pkg::in_item_t it, bit emit);
        int unsigned        limit;
        tks_pkg::out_item_t r;
        limit = (keep_reg == 0) ? 1 :
                ((keep_reg > tks_pkg::CAPACITY) ? tks_pkg::CAPACITY : keep_reg);
        if (it.operation == tks_pkg::OP_OFFER)
        begin
            if (kept_count < limit)
                insert_kept(it.score, it.item_tag);
            else if (kept_count > 0 && it.score > kept_score[kept_count-1])
            begin
                kept_count--;
                insert_kept(it.score, it.item_tag);
            end
        end
        else
        begin
            if (kept_count == 0)
            begin
                r = '{out_score: '0, out_tag: '0, is_empty: 1'b1, last: 1'b1};
                if (emit)
                    drain_expect = {drain_expect, r};
            end
            for (int unsigned k = 0; k < kept_count; k++)
            begin
                r = '{out_score: kept_score[k], out_tag: kept_tag[k], is_empty: 1'b0,
                      last: (k + 1 == kept_count)};
                if (emit)
                    drain_expect = {drain_expect, r};
            end
            kept_count = 0;
        end
    endfunction

    // Monitor: predicts on each accepted item, then checks each accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                items_taken++;
                if (item.operation == tks_pkg::OP_DRAIN)
                    drains_taken++;
                predict_selector(item, !item_typed);
                if (item_typed)
                    drain_expect = {drain_expect, item_typed_exp};
            end
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (drain_expect.size() == 0)
                    report_mismatch("result with nothing expected", 64'(result), '0);
                else
                begin
                    want = drain_expect.pop_front();
                    if (result.out_score !== want.out_score)
                        report_mismatch("out_score", 64'(result.out_score), 64'(want.out_score));
                    if (result.out_tag !== want.out_tag)
                        report_mismatch("out_tag", 64'(result.out_tag), 64'(want.out_tag));
                    if (result.is_empty !== want.is_empty)
                        report_mismatch("is_empty", 64'(result.is_empty), 64'(want.is_empty));
                    if (result.last !== want.last)
                        report_mismatch("last", 64'(result.last), 64'(want.last));
                end
            end
        end
    end

    // Receiver: either always ready, or alternating ready runs and stalls.
    always @(posedge clk)
    begin
        if (!rx_stalling)
            result_ready <= 1'b1;
        else
        begin
            if (rx_left == 0)
            begin
                rx_on   = !rx_on;
                rx_left = rx_on ? $urandom_range(1, 10) : $urandom_range(1, 8);
            end
            rx_left--;
            result_ready <= rx_on;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one item and waits for its acceptance, then perhaps a gap between bursts.
    task automatic send_item(tks_pkg::in_item_t it, bit typed, tks_pkg::out_item_t typed_res);
        int unsigned gap;
        item           <= it;
        item_typed     <= typed;
        item_typed_exp <= typed_res;
        item_valid     <= 1'b1;
        do @(posedge clk); while (!item_ready);
        gap = 0;
        if (tx_bursty)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender until every expected result has come and the last insert is done.
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (drain_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes a register, then reads keep_count back and checks it.
    task automatic write_reg(logic [tks_pkg::PADDR_W-1:0] addr,
                             logic [tks_pkg::PDATA_W-1:0] data);
        logic [tks_pkg::PDATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        reg_writes++;
        if (addr == tks_pkg::ADDR_KEEP_COUNT)
            keep_reg = data[tks_pkg::KEEP_W-1:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= tks_pkg::ADDR_KEEP_COUNT;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== tks_pkg::PDATA_W'(keep_reg))
            report_mismatch("keep_count read back", 64'(rd), 64'(keep_reg));
    endtask

    function automatic void add_offer(logic [tks_pkg::SCORE_W-1:0] s,
                                      logic [tks_pkg::TAG_BITS-1:0] t);
        plan_row_t row;
        row = '{ROW_ITEM, '{tks_pkg::OP_OFFER, s, t}, 1'b0, '0, '0, '0};
        plan = {plan, row};
    endfunction

    function automatic void add_drain(bit typed, tks_pkg::out_item_t exp_res);
        plan_row_t row;
        row = '{ROW_ITEM, '{tks_pkg::OP_DRAIN, 32'h5A5A_5A5A, 16'hA5A5}, typed, exp_res,
                '0, '0};
        plan = {plan, row};
    endfunction

    function automatic void add_cfg(logic [tks_pkg::PADDR_W-1:0] addr,
                                    logic [tks_pkg::PDATA_W-1:0] data);
        plan_row_t row;
        row = '{ROW_CFG, '0, 1'b0, '0, addr, data};
        plan = {plan, row};
    endfunction

    // Scores: full range, a narrow band that gives ties, the two extremes and small values near zero.
    function automatic logic [tks_pkg::SCORE_W-1:0] rand_score();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6:    return (32'($urandom_range(0, 6)) - 32'd3) << 16;
            7:          return 32'h7FFF_FFFF;
            8:          return 32'h8000_0000;
            default:    return 32'($urandom_range(0, 65535)) - 32'd32768;
        endcase
    endfunction

    function automatic logic [tks_pkg::KEEP_W-1:0] pick_keep();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return tks_pkg::KEEP_W'(1);
            2:       return tks_pkg::KEEP_W'(16);
            3:       return tks_pkg::KEEP_W'($urandom_range(17, 31));
            4, 5:    return tks_pkg::KEEP_W'($urandom_range(2, 6));
            default: return tks_pkg::KEEP_W'($urandom_range(2, 15));
        endcase
    endfunction

    // Main sequence: reset, directed table, random phases, drain-out and verdict.
    initial
    begin
        plan_row_t           row;
        tks_pkg::in_item_t   it;
        int unsigned         random_items;
        int unsigned         directed_items;
        int unsigned         n_offers;

        // Empty store after reset, then the score extremes and ties.
        add_drain(1'b1, '{out_score: '0, out_tag: '0, is_empty: 1'b1, last: 1'b1});
        add_offer(32'h7FFF_FFFF, 16'hFFFF);
        add_drain(1'b1, '{out_score: 32'h7FFF_FFFF, out_tag: 16'hFFFF, is_empty: 1'b0,
                          last: 1'b1});
        add_offer(32'h8000_0000, 16'h0000);
        add_offer(32'h0005_0000, 16'h0001);
        add_offer(32'h0005_0000, 16'h0002);
        add_offer(32'hFFFF_FFFF, 16'h0003);
        add_offer(32'h0064_0000, 16'h0004);
        add_drain(1'b0, '0);
        // Keep two: a tie with the minimum is refused, a higher score replaces it.
        add_cfg(tks_pkg::ADDR_KEEP_COUNT, 32'd2);
        add_offer(32'h000A_0000, 16'h0010);
        add_offer(32'h0014_0000, 16'h0020);
        add_offer(32'h000A_0000, 16'h0011);
        add_offer(32'h001E_0000, 16'h0030);
        add_drain(1'b0, '0);
        // Keep three, all at one score: the newest of them is evicted.
        add_cfg(tks_pkg::ADDR_KEEP_COUNT, 32'd3);
        add_offer(32'h0007_0000, 16'h0001);
        add_offer(32'h0007_0000, 16'h0002);
        add_offer(32'h0007_0000, 16'h0003);
        add_offer(32'h0008_0000, 16'h0004);
        add_drain(1'b0, '0);
        // A keep count of zero behaves as one.
        add_cfg(tks_pkg::ADDR_KEEP_COUNT, 32'd0);
        add_offer(32'h0003_0000, 16'h0003);
        add_offer(32'h0009_0000, 16'h0009);
        add_drain(1'b1, '{out_score: 32'h0009_0000, out_tag: 16'h0009, is_empty: 1'b0,
                          last: 1'b1});
        // Above capacity, a write to an unused address, then a keep count
        // lowered below what is already held.
        add_cfg(tks_pkg::ADDR_KEEP_COUNT, 32'hFFFF_FFFF);
        add_cfg(ADDR_SPARE, 32'd1);
        add_offer(32'h0002_0000, 16'h0102);
        add_offer(32'h0004_0000, 16'h0104);
        add_cfg(tks_pkg::ADDR_KEEP_COUNT, 32'd1);
        add_offer(32'h0003_0000, 16'h0103);
        add_drain(1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(row.addr, row.data);
            end
            else
                send_item(row.it, row.typed, row.exp);
        end
        wait_idle();
        directed_items = items_taken;

        // Random phases: offer runs closed by a drain, with some carried over.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            write_reg(tks_pkg::ADDR_KEEP_COUNT,
                      ($urandom() & ~32'h1F) | tks_pkg::PDATA_W'(pick_keep()));
            rx_stalling <= ($urandom_range(0, 3) != 0);
            tx_bursty   = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 4))
            begin
                n_offers = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 30)
                                                       : $urandom_range(0, 8);
                repeat (n_offers)
                begin
                    it = '{operation: tks_pkg::OP_OFFER, score: rand_score(),
                           item_tag: tks_pkg::TAG_BITS'($urandom())};
                    send_item(it, 1'b0, '0);
                    random_items++;
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    it = '{operation: tks_pkg::OP_DRAIN, score: $urandom(),
                           item_tag: tks_pkg::TAG_BITS'($urandom())};
                    send_item(it, 1'b0, '0);
                    random_items++;
                end
                if ($urandom_range(0, 5) == 0)
                    wait_idle();
            end
            wait_idle();
        end

        // Let any stray result show up before the verdict.
        wait_idle();
        repeat (40) @(posedge clk);
        if (drain_expect.size() != 0)
            report_mismatch("results never delivered", 64'(drain_expect.size()), '0);

        $display("Covered %0d items (%0d directed), %0d drains giving %0d results,",
                 items_taken, directed_items, drains_taken, results_seen);
        $display("and %0d register writes across keep counts from zero to 31.", reg_writes);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== top_k_score_selector_unit.f =====
design/tks_pkg.sv
design/tks_ctrl.sv
design/tks_datapath.sv
design/top_k_score_selector_unit.sv
bench/tb_top.sv
